// ===== src/lss_pkg.sv =====
// Shared widths, request codes, status codes and control types of the search stack.
`timescale 1ns / 1ps

package lss_pkg;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int MATCH_W  = 7;

    localparam logic [OP_W-1:0] OP_PUSH        = 3'd0;
    localparam logic [OP_W-1:0] OP_POP         = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK        = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_TOP     = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;
    localparam logic [OP_W-1:0] OP_COUNT       = 3'd5;
    localparam logic [OP_W-1:0] OP_ALL_SMALLER = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic start;
        logic hit;
    } t_scan_ctrl;

endpackage

// ===== src/lss_if.sv =====
// Request and result channel interfaces of the search stack.
`timescale 1ns / 1ps

interface lss_req_if;
    logic                        valid;
    logic                        ready;
    logic [lss_pkg::OP_W-1:0]    op;
    logic [lss_pkg::VALUE_W-1:0] value;

    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

interface lss_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lss_pkg::VALUE_W-1:0]  read_data;
    logic [lss_pkg::STATUS_W-1:0] status;
    logic [lss_pkg::MATCH_W-1:0]  match_count;
    logic                         value_exceeds_all;
    logic                         now_empty;

    modport source (output valid, read_data, status, match_count, value_exceeds_all,
                    now_empty, input ready);
    modport sink   (input valid, read_data, status, match_count, value_exceeds_all,
                    now_empty, output ready);
endinterface

// ===== src/lss_scan.sv =====
// Match counter and all-smaller flag accumulated over entries streamed from the store.
`timescale 1ns / 1ps

module lss_scan #(
    parameter int DATA_WIDTH = 32,
    parameter int COUNT_W    = 7
) (
    input  logic                   i_clk,
    input  lss_pkg::t_scan_ctrl    i_ctrl,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic [DATA_WIDTH-1:0]  i_entry,
    output logic [COUNT_W-1:0]     o_count,
    output logic                   o_exceeds
);

    logic [COUNT_W-1:0] r_count;
    logic               r_exceeds;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_count   <= '0;
            r_exceeds <= 1'b1;
        end else if (i_ctrl.hit) begin
            if (i_entry == i_value) begin
                r_count <= r_count + 1'b1;
            end
            // drop the flag once any entry reaches the value
            if (i_value <= i_entry) begin
                r_exceeds <= 1'b0;
            end
        end
    end

    assign o_count   = r_count;
    assign o_exceeds = r_exceeds;

endmodule

// ===== src/lifo_stack_with_search.sv =====
// Top level of the bounded last-in first-out store with count and all-smaller search.
`timescale 1ns / 1ps

// One request is taken at a time and gives one result. Push, clear, unused codes and
// every request on an empty store go straight from acceptance to the done state.
// Pop, peek and pop-returning-top on a non-empty store first pass the top state, since
// the top entry comes from a synchronous single-read-port memory. Count and all-smaller
// requests on a non-empty store walk the stored entries one per cycle through that
// read port in the scan state. The store needs no clearing pass after reset: only
// entries below the fill level are ever read. A new request is taken while an earlier
// result still waits in the output register; its own result then holds in the done
// state until that register frees.
module lifo_stack_with_search #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lss_req_if.sink       i_req,
    lss_rsp_if.source     o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int XW = (DATA_WIDTH > lss_pkg::VALUE_W) ? DATA_WIDTH : lss_pkg::VALUE_W;
    localparam int MW = (LW > lss_pkg::MATCH_W) ? LW : lss_pkg::MATCH_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                       r_state;
    logic [LW-1:0]                r_fill;
    logic [LW-1:0]                r_issue;
    logic                         r_rd_vld;
    logic [lss_pkg::OP_W-1:0]     r_op;
    logic [DATA_WIDTH-1:0]        r_val;
    logic [DATA_WIDTH-1:0]        r_top;
    logic [lss_pkg::STATUS_W-1:0] r_status;

    logic                         r_out_valid;
    logic [lss_pkg::VALUE_W-1:0]  r_out_read_data;
    logic [lss_pkg::STATUS_W-1:0] r_out_status;
    logic [lss_pkg::MATCH_W-1:0]  r_out_count;
    logic                         r_out_exceeds;
    logic                         r_out_empty;

    logic [DATA_WIDTH-1:0]        r_mem [DEPTH];
    logic [DATA_WIDTH-1:0]        r_rd_data;

    logic                         w_accept;
    logic                         w_full;
    logic                         w_empty;
    logic [XW-1:0]                w_val_ext;
    logic [DATA_WIDTH-1:0]        w_val;
    logic [LW-1:0]                w_fill_m1;
    logic                         w_wr_en;
    logic [AW-1:0]                w_wr_addr;
    logic                         w_rd_en;
    logic [AW-1:0]                w_rd_addr;
    logic                         w_out_free;
    logic [XW-1:0]                w_top_ext;
    logic [LW-1:0]                w_scan_count;
    logic [MW-1:0]                w_count_ext;
    logic                         w_scan_exceeds;
    lss_pkg::t_scan_ctrl          w_scan_ctrl;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_full     = (r_fill == LW'(DEPTH));
    assign w_empty    = (r_fill == '0);
    assign w_val_ext  = XW'(i_req.value);
    assign w_val      = w_val_ext[DATA_WIDTH-1:0];
    assign w_fill_m1  = r_fill - 1'b1;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_top_ext  = XW'(r_top);
    assign w_count_ext = MW'(w_scan_count);

    assign i_req.ready = (r_state == S_IDLE);

    // Push writes in the accept cycle; any read of that entry is issued at the next
    // accept at the earliest, after the write has landed, so no forwarding is needed.
    always_comb begin
        w_wr_en   = w_accept && (i_req.op == lss_pkg::OP_PUSH) && !w_full;
        w_wr_addr = r_fill[AW-1:0];
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (w_accept && !w_empty) begin
            if (i_req.op inside {lss_pkg::OP_POP, lss_pkg::OP_PEEK, lss_pkg::OP_POP_TOP}) begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_fill_m1[AW-1:0];
            end else if (i_req.op inside {lss_pkg::OP_COUNT, lss_pkg::OP_ALL_SMALLER}) begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
            end
        end else if (r_state == S_SCAN && r_issue != r_fill) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_issue[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_val;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign w_scan_ctrl = '{start: w_accept, hit: (r_state == S_SCAN) && r_rd_vld};

    lss_scan #(
        .DATA_WIDTH (DATA_WIDTH),
        .COUNT_W    (LW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_ctrl    (w_scan_ctrl),
        .i_value   (r_val),
        .i_entry   (r_rd_data),
        .o_count   (w_scan_count),
        .o_exceeds (w_scan_exceeds)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_issue     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // the done state reloads the output register itself
            if (r_out_valid && o_rsp.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= i_req.op;
                        r_val <= w_val;
                        r_top <= '0;
                        case (i_req.op)
                            lss_pkg::OP_PUSH: begin
                                r_state  <= S_DONE;
                                r_status <= w_full ? lss_pkg::ST_FULL : lss_pkg::ST_OK;
                                if (!w_full) begin
                                    r_fill <= r_fill + 1'b1;
                                end
                            end
                            lss_pkg::OP_POP, lss_pkg::OP_PEEK, lss_pkg::OP_POP_TOP: begin
                                if (w_empty) begin
                                    r_status <= lss_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= lss_pkg::ST_OK;
                                    r_state  <= S_TOP;
                                end
                            end
                            lss_pkg::OP_CLEAR: begin
                                r_status <= lss_pkg::ST_OK;
                                r_fill   <= '0;
                                r_state  <= S_DONE;
                            end
                            lss_pkg::OP_COUNT, lss_pkg::OP_ALL_SMALLER: begin
                                r_status <= lss_pkg::ST_OK;
                                if (!w_empty) begin
                                    r_issue  <= LW'(1);
                                    r_rd_vld <= 1'b1;
                                    r_state  <= S_SCAN;
                                end else begin
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                r_status <= lss_pkg::ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_TOP: begin
                    if (r_op != lss_pkg::OP_POP) begin
                        r_top <= r_rd_data;
                    end
                    if (r_op != lss_pkg::OP_PEEK) begin
                        r_fill <= w_fill_m1;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    if (r_issue != r_fill) begin
                        r_issue  <= r_issue + 1'b1;
                        r_rd_vld <= 1'b1;
                    end else begin
                        // last entry compared once the read pipe has drained
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid     <= 1'b1;
                        r_out_read_data <= w_top_ext[lss_pkg::VALUE_W-1:0];
                        r_out_status    <= r_status;
                        r_out_count     <= (r_op == lss_pkg::OP_COUNT) ?
                                           w_count_ext[lss_pkg::MATCH_W-1:0] : '0;
                        r_out_exceeds   <= (r_op == lss_pkg::OP_ALL_SMALLER) &&
                                           w_scan_exceeds;
                        r_out_empty     <= w_empty;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.read_data         = r_out_read_data;
    assign o_rsp.status            = r_out_status;
    assign o_rsp.match_count       = r_out_count;
    assign o_rsp.value_exceeds_all = r_out_exceeds;
    assign o_rsp.now_empty         = r_out_empty;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(DEPTH))
        else $error("fill level beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req.op == lss_pkg::OP_PUSH && !w_full |=>
        r_fill == $past(r_fill) + 1'b1)
        else $error("accepted push did not advance fill level");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_issue <= r_fill && r_issue != '0)
        else $error("scan read index outside stored entries");

    a_done_needs_idle_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && w_out_free |=> r_out_valid && r_state == S_IDLE)
        else $error("result not loaded into output register");

endmodule
